// ----- hw/rtl/clw_pkg.sv -----
// ----------------------------------------------------------------------------
// clw_pkg
// Widths, types and pipeline depths shared by the cotangent weight block.
// ----------------------------------------------------------------------------
package clw_pkg;

    localparam int IDX_W     = 20;
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DOT_W     = PROD_W + 1;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int HALF_W    = MAG_W / 2;
    localparam int RAD_W     = 2 * MAG_W;
    localparam int ROOT_W    = MAG_W;
    localparam int SQR_W     = ROOT_W + 2;
    localparam int NUM_W     = PROD_W;
    localparam int EPS_W     = 32;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int FRAC_SHIFT = 15;
    localparam int QUO_W     = 33;
    localparam int LOW_W     = QUO_W - FRAC_SHIFT;
    localparam int HIGH_W    = NUM_W - LOW_W;
    localparam int WEIGHT_W  = 32;

    localparam int FRONT_LAT = 6;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUO_W + 3;
    localparam int LATENCY   = 1 + FRONT_LAT + SQRT_LAT + DIV_LAT;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd17592186;

    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic [WEIGHT_W-1:0]        weight_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        idx_t   index_a;
        idx_t   index_b;
        idx_t   index_c;
        coord_t a_x;
        coord_t a_y;
        coord_t a_z;
        coord_t b_x;
        coord_t b_y;
        coord_t b_z;
        coord_t c_x;
        coord_t c_y;
        coord_t c_z;
    } item_t;

    typedef struct packed {
        weight_t weight_ab;
        weight_t weight_bc;
        weight_t weight_ca;
        idx_t    out_index_a;
        idx_t    out_index_b;
        idx_t    out_index_c;
        logic    saturated;
    } result_t;

    typedef struct packed {
        weight_t weight;
        logic    sat;
    } lane_res_t;

endpackage

// ----- hw/rtl/clw_front.sv -----
// ----------------------------------------------------------------------------
// clw_front
// Edge vectors, dot and cross products, squared cross magnitude (6 stages).
// ----------------------------------------------------------------------------
module clw_front
    import clw_pkg::*;
(
    input  logic              clk,
    input  point_t            p,
    input  point_t            q,
    input  point_t            k,
    output logic [RAD_W-1:0]  rad,
    output logic [NUM_W-1:0]  num,
    output logic              neg
);

    logic signed [COORD_W-1:0] p_c [3];
    logic signed [COORD_W-1:0] q_c [3];
    logic signed [COORD_W-1:0] k_c [3];

    logic signed [DIFF_W-1:0]  u_reg [3];
    logic signed [DIFF_W-1:0]  v_reg [3];
    logic signed [PROD_W-1:0]  pd_reg [3];
    logic signed [PROD_W-1:0]  pca_reg [3];
    logic signed [PROD_W-1:0]  pcb_reg [3];
    logic signed [DOT_W-1:0]   dot_reg;
    logic [MAG_W-1:0]          mag_reg [3];
    logic [MAG_W-1:0]          hh_reg [3];
    logic [MAG_W-1:0]          hl_reg [3];
    logic [MAG_W-1:0]          ll_reg [3];
    logic [NUM_W-1:0]          num4_reg, num5_reg, num6_reg;
    logic                      neg4_reg, neg5_reg, neg6_reg;
    logic [RAD_W-1:0]          sq_reg [3];
    logic [RAD_W-1:0]          rad_reg;

    logic signed [DOT_W-1:0]   dot_next;
    logic signed [CROSS_W-1:0] cross_c [3];
    logic [MAG_W-1:0]          mag_next [3];

    assign p_c[0] = p.x;  assign p_c[1] = p.y;  assign p_c[2] = p.z;
    assign q_c[0] = q.x;  assign q_c[1] = q.y;  assign q_c[2] = q.z;
    assign k_c[0] = k.x;  assign k_c[1] = k.y;  assign k_c[2] = k.z;

    always_comb
    begin
        dot_next = {pd_reg[0][PROD_W-1], pd_reg[0]} + {pd_reg[1][PROD_W-1], pd_reg[1]}
                 + {pd_reg[2][PROD_W-1], pd_reg[2]};
        for (int i = 0; i < 3; i++)
        begin
            cross_c[i] = {pca_reg[i][PROD_W-1], pca_reg[i]}
                       - {pcb_reg[i][PROD_W-1], pcb_reg[i]};
            if (cross_c[i][CROSS_W-1])
                mag_next[i] = MAG_W'(-cross_c[i]);
            else
                mag_next[i] = cross_c[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_reg[i] <= {p_c[i][COORD_W-1], p_c[i]} - {k_c[i][COORD_W-1], k_c[i]};
            v_reg[i] <= {q_c[i][COORD_W-1], q_c[i]} - {k_c[i][COORD_W-1], k_c[i]};
            pd_reg[i] <= u_reg[i] * v_reg[i];
        end
        pca_reg[0] <= u_reg[1] * v_reg[2];
        pcb_reg[0] <= u_reg[2] * v_reg[1];
        pca_reg[1] <= u_reg[2] * v_reg[0];
        pcb_reg[1] <= u_reg[0] * v_reg[2];
        pca_reg[2] <= u_reg[0] * v_reg[1];
        pcb_reg[2] <= u_reg[1] * v_reg[0];

        dot_reg <= dot_next;
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i] <= mag_next[i];
            // split square into partial products of 25-bit halves
            hh_reg[i] <= mag_reg[i][MAG_W-1:HALF_W] * mag_reg[i][MAG_W-1:HALF_W];
            hl_reg[i] <= mag_reg[i][MAG_W-1:HALF_W] * mag_reg[i][HALF_W-1:0];
            ll_reg[i] <= mag_reg[i][HALF_W-1:0] * mag_reg[i][HALF_W-1:0];
            sq_reg[i] <= (RAD_W'(hh_reg[i]) << MAG_W) + (RAD_W'(hl_reg[i]) << (HALF_W + 1))
                       + RAD_W'(ll_reg[i]);
        end
        neg4_reg <= dot_reg[DOT_W-1];
        num4_reg <= dot_reg[DOT_W-1] ? NUM_W'(-dot_reg) : dot_reg[NUM_W-1:0];
        num5_reg <= num4_reg;
        neg5_reg <= neg4_reg;
        num6_reg <= num5_reg;
        neg6_reg <= neg5_reg;
        rad_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    assign rad = rad_reg;
    assign num = num6_reg;
    assign neg = neg6_reg;

endmodule

// ----- hw/rtl/clw_isqrt.sv -----
// ----------------------------------------------------------------------------
// clw_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module clw_isqrt
    import clw_pkg::*;
(
    input  logic              clk,
    input  logic [RAD_W-1:0]  rad,
    input  logic [NUM_W-1:0]  num_in,
    input  logic              neg_in,
    output logic [ROOT_W-1:0] root,
    output logic [NUM_W-1:0]  num_out,
    output logic              neg_out
);

    logic [SQR_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [NUM_W-1:0]  num_reg  [ROOT_W];
    logic              neg_reg  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        logic [SQR_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RAD_W-1:0]  rad_prev;
        logic [NUM_W-1:0]  num_prev;
        logic              neg_prev;
        logic [SQR_W+1:0]  trial_num;
        logic [SQR_W+1:0]  trial_sub;

        if (j == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
            assign num_prev  = num_in;
            assign neg_prev  = neg_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign rad_prev  = rad_reg[j-1];
            assign num_prev  = num_reg[j-1];
            assign neg_prev  = neg_reg[j-1];
        end

        assign trial_num = {rem_prev, rad_prev[RAD_W-1 -: 2]};
        assign trial_sub = {2'b00, root_prev, 2'b01};

        always_ff @(posedge clk)
        begin
            if (trial_num >= trial_sub)
            begin
                rem_reg[j]  <= SQR_W'(trial_num - trial_sub);
                root_reg[j] <= {root_prev[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j]  <= SQR_W'(trial_num);
                root_reg[j] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
            rad_reg[j] <= {rad_prev[RAD_W-3:0], 2'b00};
            num_reg[j] <= num_prev;
            neg_reg[j] <= neg_prev;
        end
    end

    assign root    = root_reg[ROOT_W-1];
    assign num_out = num_reg[ROOT_W-1];
    assign neg_out = neg_reg[ROOT_W-1];

endmodule

// ----- hw/rtl/clw_divide.sv -----
// ----------------------------------------------------------------------------
// clw_divide
// Pipelined restoring divide of |dot|*2^15 by (root + eps), then clipping.
// ----------------------------------------------------------------------------
module clw_divide
    import clw_pkg::*;
(
    input  logic              clk,
    input  logic [ROOT_W-1:0] root,
    input  logic [NUM_W-1:0]  num,
    input  logic              neg,
    input  logic [EPS_W-1:0]  eps,
    output lane_res_t         res
);

    localparam logic [QUO_W-1:0] POS_MAX = QUO_W'({1'b0, {(WEIGHT_W-1){1'b1}}});
    localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'({1'b1, {(WEIGHT_W-1){1'b0}}});

    logic [DEN_W-1:0] den_a_reg;
    logic [NUM_W-1:0] num_a_reg;
    logic             neg_a_reg;

    logic [DEN_W-1:0] den_b_reg;
    logic [REM_W-1:0] rem_b_reg;
    logic [LOW_W-1:0] low_b_reg;
    logic             neg_b_reg, over_b_reg, zero_b_reg;

    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [REM_W-1:0] rem_reg  [QUO_W];
    logic [LOW_W-1:0] low_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic             neg_reg  [QUO_W];
    logic             over_reg [QUO_W];
    logic             zero_reg [QUO_W];

    lane_res_t        res_reg, res_next;
    logic [QUO_W-1:0] clip;

    always_ff @(posedge clk)
    begin
        den_a_reg  <= DEN_W'(root) + DEN_W'(eps);
        num_a_reg  <= num;
        neg_a_reg  <= neg;
        // quotient would not fit in QUO_W bits: clipped anyway
        over_b_reg <= (num_a_reg != '0) && (DEN_W'(num_a_reg[NUM_W-1:LOW_W]) >= den_a_reg);
        zero_b_reg <= (num_a_reg == '0);
        rem_b_reg  <= REM_W'(num_a_reg[NUM_W-1:LOW_W]);
        low_b_reg  <= num_a_reg[LOW_W-1:0];
        den_b_reg  <= den_a_reg;
        neg_b_reg  <= neg_a_reg;
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_step
        logic [DEN_W-1:0] den_prev;
        logic [REM_W-1:0] rem_prev;
        logic [LOW_W-1:0] low_prev;
        logic [QUO_W-1:0] quo_prev;
        logic             neg_prev, over_prev, zero_prev;
        logic [REM_W-1:0] shifted;

        if (j == 0)
        begin : g_first
            assign den_prev  = den_b_reg;
            assign rem_prev  = rem_b_reg;
            assign low_prev  = low_b_reg;
            assign quo_prev  = '0;
            assign neg_prev  = neg_b_reg;
            assign over_prev = over_b_reg;
            assign zero_prev = zero_b_reg;
        end
        else
        begin : g_next
            assign den_prev  = den_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign low_prev  = low_reg[j-1];
            assign quo_prev  = quo_reg[j-1];
            assign neg_prev  = neg_reg[j-1];
            assign over_prev = over_reg[j-1];
            assign zero_prev = zero_reg[j-1];
        end

        assign shifted = {rem_prev[REM_W-2:0], low_prev[LOW_W-1]};

        always_ff @(posedge clk)
        begin
            if (shifted >= {1'b0, den_prev})
            begin
                rem_reg[j] <= shifted - {1'b0, den_prev};
                quo_reg[j] <= {quo_prev[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[j] <= shifted;
                quo_reg[j] <= {quo_prev[QUO_W-2:0], 1'b0};
            end
            low_reg[j]  <= {low_prev[LOW_W-2:0], 1'b0};
            den_reg[j]  <= den_prev;
            neg_reg[j]  <= neg_prev;
            over_reg[j] <= over_prev;
            zero_reg[j] <= zero_prev;
        end
    end

    always_comb
    begin
        res_next.sat = 1'b0;
        clip         = quo_reg[QUO_W-1];
        if (zero_reg[QUO_W-1])
        begin
            clip = '0;
        end
        else if (neg_reg[QUO_W-1])
        begin
            if (over_reg[QUO_W-1] || (clip > NEG_MAX))
            begin
                clip         = NEG_MAX;
                res_next.sat = 1'b1;
            end
        end
        else if (over_reg[QUO_W-1] || (clip > POS_MAX))
        begin
            clip         = POS_MAX;
            res_next.sat = 1'b1;
        end
        if (neg_reg[QUO_W-1])
            res_next.weight = WEIGHT_W'(-clip);
        else
            res_next.weight = clip[WEIGHT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- hw/rtl/cotan_laplacian_weights.sv -----
// ----------------------------------------------------------------------------
// cotan_laplacian_weights
// Half-cotangent edge weights for one triangle per clock, Q16.16 output.
// ----------------------------------------------------------------------------
// A triangle is taken on every cycle that start is high (busy is always low).
// Its three weights, indices and saturation flag are shown with done when
// the triangle leaves the pipeline. The depth is the input register, six
// front-end stages for differences, products and squares, the square root of
// the cross magnitude (one root bit per stage, 50 stages) and the divide (two
// set-up stages, 33 quotient bits one per stage, one clipping stage).
// Results cannot be held off; every transaction is presented once.
module cotan_laplacian_weights
    import clw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             epsilon_we,
    input  logic [EPS_W-1:0] epsilon_data
);

    item_t            in_reg;
    logic [EPS_W-1:0] eps_reg;
    logic [LATENCY-1:0] valid_reg;
    logic [3*IDX_W-1:0] idx_reg [LATENCY];

    point_t           pts [3];
    lane_res_t        lane_res [3];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg   <= EPS_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (epsilon_we)
                eps_reg <= epsilon_data;
            valid_reg <= {valid_reg[LATENCY-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= item;
        idx_reg[0] <= {item.index_a, item.index_b, item.index_c};
        for (int i = 1; i < LATENCY; i++)
            idx_reg[i] <= idx_reg[i-1];
    end

    assign pts[0] = '{x: in_reg.a_x, y: in_reg.a_y, z: in_reg.a_z};
    assign pts[1] = '{x: in_reg.b_x, y: in_reg.b_y, z: in_reg.b_z};
    assign pts[2] = '{x: in_reg.c_x, y: in_reg.c_y, z: in_reg.c_z};

    // lane j: corner opposite edge j -> j+1
    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        logic [RAD_W-1:0]  rad;
        logic [NUM_W-1:0]  num_f, num_s;
        logic              neg_f, neg_s;
        logic [ROOT_W-1:0] root;

        clw_front u_front (
            .clk (clk),
            .p   (pts[j]),
            .q   (pts[(j + 1) % 3]),
            .k   (pts[(j + 2) % 3]),
            .rad (rad),
            .num (num_f),
            .neg (neg_f)
        );

        clw_isqrt u_isqrt (
            .clk     (clk),
            .rad     (rad),
            .num_in  (num_f),
            .neg_in  (neg_f),
            .root    (root),
            .num_out (num_s),
            .neg_out (neg_s)
        );

        clw_divide u_divide (
            .clk  (clk),
            .root (root),
            .num  (num_s),
            .neg  (neg_s),
            .eps  (eps_reg),
            .res  (lane_res[j])
        );
    end

    assign done               = valid_reg[LATENCY-1];
    assign result.weight_ab   = lane_res[0].weight;
    assign result.weight_bc   = lane_res[1].weight;
    assign result.weight_ca   = lane_res[2].weight;
    assign result.out_index_a = idx_reg[LATENCY-1][3*IDX_W-1 -: IDX_W];
    assign result.out_index_b = idx_reg[LATENCY-1][2*IDX_W-1 -: IDX_W];
    assign result.out_index_c = idx_reg[LATENCY-1][IDX_W-1:0];
    assign result.saturated   = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;

endmodule

// ----- hw/rtl/clw_checker.sv -----
// ----------------------------------------------------------------------------
// clw_checker
// Port-level checks on the cotangent weight block, bound to the top level.
// ----------------------------------------------------------------------------
module clw_checker
    import clw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input item_t            item,
    input logic             done,
    input result_t          result,
    input logic             epsilon_we,
    input logic [EPS_W-1:0] epsilon_data
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a non-stalling pipeline");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted transaction");

    a_index_a: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_index_a == $past(item.index_a, LATENCY)))
        else $error("index a misaligned with its transaction");

    a_index_c: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_index_c == $past(item.index_c, LATENCY)))
        else $error("index c misaligned with its transaction");

endmodule

bind cotan_laplacian_weights clw_checker u_clw_checker (.*);
